### hw/rtl/ctr_pkg.sv
// shared types, constants and helpers for the counter-from-index generator
package ctr_pkg;

  localparam int unsigned SEED_W = 31;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 46;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned NUM_STEPS = 5;

  localparam logic [WORD_W-1:0] SEED_BASE  = 32'd23456911;
  localparam logic [SEED_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [14:0]       LEHMER_MUL = 15'd16807;

  typedef struct packed {
    logic [SEED_W-1:0]                    s;
    logic                                 err;
    logic [NUM_WORDS-1:0][WORD_W-1:0]     words;
  } item_t;

  function automatic logic [WORD_W-1:0] neg_word(input logic [SEED_W-1:0] s);
    neg_word = {WORD_W{1'b0}} - {1'b0, s};
  endfunction

endpackage

### hw/rtl/ctr_seed.sv
// seed stage: base offset, optional halving and range check
module ctr_seed (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      halve_large_seed,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [30:0]               entry_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ctr_pkg::item_t            out_item
);

  logic [ctr_pkg::WORD_W-1:0] seed_sum;
  logic                       at_or_above;
  logic                       above;
  ctr_pkg::item_t             item_next;

  assign seed_sum    = ctr_pkg::SEED_BASE + {1'b0, entry_index};
  assign at_or_above = seed_sum >= {1'b0, ctr_pkg::LEHMER_MOD};
  assign above       = seed_sum >  {1'b0, ctr_pkg::LEHMER_MOD};
  assign in_ready    = !out_valid || out_ready;

  always_comb begin
    item_next       = '0;
    item_next.words = '0;
    if (halve_large_seed && at_or_above) begin
      item_next.s   = seed_sum[ctr_pkg::WORD_W-1:1];
      item_next.err = 1'b0;
    end else begin
      item_next.s   = seed_sum[ctr_pkg::SEED_W-1:0];
      item_next.err = !halve_large_seed && above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

### hw/rtl/ctr_lehmer_step.sv
// one park-miller step in two stages: multiply, then mersenne fold
module ctr_lehmer_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctr_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ctr_pkg::item_t out_item
);

  logic                        a_valid;
  logic                        a_ready;
  logic [ctr_pkg::PROD_W-1:0]  a_prod;
  ctr_pkg::item_t              a_item;
  logic [ctr_pkg::WORD_W-1:0]  fold;
  logic [ctr_pkg::WORD_W-1:0]  fold_red;
  ctr_pkg::item_t              out_item_next;

  assign in_ready = !a_valid || a_ready;
  assign a_ready  = !out_valid || out_ready;

  // 2^31 == 1 mod m, so high and low halves add
  assign fold = {17'b0, a_prod[ctr_pkg::PROD_W-1:ctr_pkg::SEED_W]}
              + {1'b0, a_prod[ctr_pkg::SEED_W-1:0]};
  assign fold_red = (fold > {1'b0, ctr_pkg::LEHMER_MOD})
                  ? fold - {1'b0, ctr_pkg::LEHMER_MOD} : fold;

  always_comb begin
    out_item_next   = a_item;
    out_item_next.s = fold_red[ctr_pkg::SEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_prod <= {31'b0, ctr_pkg::LEHMER_MUL} * {15'b0, in_item.s};
      a_item <= in_item;
    end
    if (a_ready && a_valid) begin
      out_item <= out_item_next;
    end
  end

endmodule

### hw/rtl/ctr_counter_from_index.sv
// top level: index-to-counter generator, seed stage and five lehmer steps
// pipeline: 1 seed stage, then 2 register stages per lehmer step
// throughput: one beat per cycle while out_ready stays high; each step holds a multiply and a fold stage
// per-stage ready lets bubbles close up behind a stalled output
// reset: synchronous, clears all valid bits and sets halve_large_seed to 0
module ctr_counter_from_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] counter_word0,
  output logic [31:0] counter_word1,
  output logic [31:0] counter_word2,
  output logic [31:0] counter_word3,
  output logic        seed_range_error
);

  logic                    halve_large_seed;
  logic                    lnk_valid [ctr_pkg::NUM_STEPS+1];
  logic                    lnk_ready [ctr_pkg::NUM_STEPS+1];
  ctr_pkg::item_t          lnk_item  [ctr_pkg::NUM_STEPS+1];
  ctr_pkg::item_t          fed_item  [ctr_pkg::NUM_STEPS];
  ctr_pkg::item_t          last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      halve_large_seed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      halve_large_seed <= cfg_data;
    end
  end

  ctr_seed u_seed (
    .clk              (clk),
    .rst              (rst),
    .halve_large_seed (halve_large_seed),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .entry_index      (entry_index),
    .out_valid        (lnk_valid[0]),
    .out_ready        (lnk_ready[0]),
    .out_item         (lnk_item[0])
  );

  for (genvar i = 0; i < ctr_pkg::NUM_STEPS; i++) begin : g_step
    if (i >= 2) begin : g_word
      always_comb begin
        fed_item[i]          = lnk_item[i];
        fed_item[i].words[i-2] = ctr_pkg::neg_word(lnk_item[i].s);
      end
    end else begin : g_pass
      assign fed_item[i] = lnk_item[i];
    end

    ctr_lehmer_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lnk_valid[i]),
      .in_ready  (lnk_ready[i]),
      .in_item   (fed_item[i]),
      .out_valid (lnk_valid[i+1]),
      .out_ready (lnk_ready[i+1]),
      .out_item  (lnk_item[i+1])
    );
  end

  assign last                              = lnk_item[ctr_pkg::NUM_STEPS];
  assign out_valid                         = lnk_valid[ctr_pkg::NUM_STEPS];
  assign lnk_ready[ctr_pkg::NUM_STEPS]     = out_ready;

  // range error forces all words to zero
  assign counter_word0    = last.err ? '0 : last.words[0];
  assign counter_word1    = last.err ? '0 : last.words[1];
  assign counter_word2    = last.err ? '0 : last.words[2];
  assign counter_word3    = last.err ? '0 : ctr_pkg::neg_word(last.s);
  assign seed_range_error = last.err;

endmodule

### verif/ctr_counter_from_index_test.sv
// self-checking testbench for the index-to-counter generator with random flow control
`timescale 1ns / 100ps

module ctr_counter_from_index_test;

  localparam longint SCHRAGE_Q = 127773;
  localparam longint SCHRAGE_R = 2836;
  localparam longint MODULUS = longint'(ctr_pkg::LEHMER_MOD);
  localparam int PIPE_LATENCY = 11;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 500;
  localparam logic [30:0] EDGE_INDEX = 31'd2124026736;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [30:0] entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] counter_word0;
  logic [31:0] counter_word1;
  logic [31:0] counter_word2;
  logic [31:0] counter_word3;
  logic        seed_range_error;

  typedef struct packed {
    logic [ctr_pkg::NUM_WORDS-1:0][ctr_pkg::WORD_W-1:0] word;
    logic                                               range_err;
  } counter_t;

  class counter_scoreboard;
    counter_t expected_q[$];
    int errors;
    int n_checked;
    int n_range_err;
    int n_halved;

    function new();
      errors = 0;
      n_checked = 0;
      n_range_err = 0;
      n_halved = 0;
    endfunction

    function logic [30:0] lehmer_next(logic [30:0] s);
      longint sl;
      longint hi;
      longint lo;
      longint t;
      sl = longint'(s);
      hi = sl / SCHRAGE_Q;
      lo = sl - hi * SCHRAGE_Q;
      t = longint'(ctr_pkg::LEHMER_MUL) * lo - SCHRAGE_R * hi;
      if (t <= 0) begin
        t = t + MODULUS;
      end
      return t[30:0];
    endfunction

    function void note_index(logic [30:0] idx, bit halve);
      counter_t e;
      longint seed;
      logic [30:0] s;
      e = '0;
      seed = longint'(ctr_pkg::SEED_BASE) + longint'(idx);
      if (halve) begin
        if (seed >= MODULUS) begin
          seed = seed >> 1;
          n_halved++;
        end
      end else if (seed > MODULUS) begin
        e.range_err = 1'b1;
      end
      if (!e.range_err) begin
        s = lehmer_next(seed[30:0]);
        for (int k = 0; k < ctr_pkg::NUM_WORDS; k++) begin
          s = lehmer_next(s);
          e.word[k] = 32'h0 - 32'(s);
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_counter(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                logic [31:0] w3, logic err);
      counter_t e;
      logic [ctr_pkg::NUM_WORDS-1:0][ctr_pkg::WORD_W-1:0] got;
      got[0] = w0;
      got[1] = w1;
      got[2] = w2;
      got[3] = w3;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: counter_word0 %h seed_range_error %b", w0, err);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (err) n_range_err++;
      for (int k = 0; k < ctr_pkg::NUM_WORDS; k++) begin
        if (got[k] !== e.word[k]) begin
          $error("counter_word%0d expected %h actual %h", k, e.word[k], got[k]);
          errors++;
        end
      end
      if (err !== e.range_err) begin
        $error("seed_range_error expected %b actual %b", e.range_err, err);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  counter_scoreboard sb;
  bit halve_mode;
  int cfg_writes;
  int idle_cycles;
  int burst_left;
  int rx_mode;
  int rx_left;

  ctr_counter_from_index dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .entry_index     (entry_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .counter_word0   (counter_word0),
    .counter_word1   (counter_word1),
    .counter_word2   (counter_word2),
    .counter_word3   (counter_word3),
    .seed_range_error(seed_range_error)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (rx_left % 6) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        halve_mode = cfg_data;
        cfg_writes++;
      end
      if (in_valid && in_ready) sb.note_index(entry_index, halve_mode);
      if (out_valid && out_ready) begin
        sb.check_counter(counter_word0, counter_word1, counter_word2, counter_word3,
                         seed_range_error);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_index(input logic [30:0] idx, input bit last);
    int gap;
    in_valid <= 1'b1;
    entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
    if (last || gap > 0) in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_halve(input bit value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] rand_index();
    logic [30:0] idx;
    case ($urandom_range(0, 9))
      4, 5: idx = EDGE_INDEX + 31'($urandom_range(0, 80)) - 31'd40;
      6: idx = 31'h7FFF_FFFF - 31'($urandom_range(0, 40));
      7: idx = 31'($urandom_range(0, 1000));
      default: idx = 31'($urandom);
    endcase
    return idx;
  endfunction

  logic [30:0] directed_idx[12];
  bit phase_halve[4];

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    entry_index = '0;
    out_ready = 1'b0;
    halve_mode = 1'b0;
    cfg_writes = 0;
    idle_cycles = 0;
    burst_left = 0;
    rx_mode = 0;
    rx_left = 0;
    directed_idx = '{31'd0, 31'd1, 31'd100, EDGE_INDEX - 31'd2, EDGE_INDEX - 31'd1,
                     EDGE_INDEX, EDGE_INDEX + 31'd1, 31'h7FFF_FFFE, 31'h7FFF_FFFF,
                     31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555};
    phase_halve = '{1'b1, 1'b0, 1'b1, 1'b0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // boundary indexes in both seed modes
    for (int m = 0; m < 2; m++) begin
      write_halve(m[0]);
      for (int i = 0; i < 12; i++) send_index(directed_idx[i], i == 11);
    end

    for (int p = 0; p < 4; p++) begin
      write_halve(phase_halve[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_index(rand_index(), i == RANDOM_PER_PHASE / 2 || i == RANDOM_PER_PHASE - 1);
        if (i == RANDOM_PER_PHASE / 2) wait_results_drained();
      end
    end

    wait_results_drained();
    $display("checked %0d counter beats over %0d register writes", sb.n_checked, cfg_writes);
    $display("%0d seeds flagged out of range, %0d seeds halved", sb.n_range_err, sb.n_halved);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ctr_pkg.sv
hw/rtl/ctr_seed.sv
hw/rtl/ctr_lehmer_step.sv
hw/rtl/ctr_counter_from_index.sv
verif/ctr_counter_from_index_test.sv
